// ===== rtl/suks_pkg.sv =====
// Package: shared constants and types for the sorted unique key set.
`default_nettype none
package suks_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int STAT_W   = 3;
    localparam int ECNT_W   = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // Broadcast control to every cell of the chain.
    typedef struct packed {
        logic compare;
        logic insert;
        logic remove;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== rtl/sorted_unique_key_set.sv =====
// Top level: sorted unique key set built from a chain of slot cells.
`default_nettype none
// A command beat (start high while busy is low) carries an insert or remove
// with a signed key. Every slot compares the key against its entry in the
// cycle the beat is taken; in the next cycle the hit is resolved and, if the
// set changes, the slots from the hit or insertion point up shift by one.
// The result beat follows in the next cycle on o_status/o_entry_count with
// o_result_valid high for a single cycle. Busy is high in the resolve cycle,
// so a new command may start as a result appears; the result cannot be held
// off. After reset the set is empty and a command may be issued at once.
module sorted_unique_key_set (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 i_command,
    input  wire logic signed [suks_pkg::KEY_W-1:0]    i_key,
    output logic                                      o_result_valid,
    output logic [suks_pkg::STAT_W-1:0]               o_status,
    output logic [suks_pkg::ECNT_W-1:0]               o_entry_count
);

    localparam int N = suks_pkg::CAPACITY;

    logic                              r_pend;
    logic                              r_cmd;
    logic signed [suks_pkg::KEY_W-1:0] r_key;
    logic [suks_pkg::CNT_W-1:0]        r_count;
    logic [suks_pkg::CNT_W-1:0]        n_count;
    logic                              r_done;
    suks_pkg::t_status                 r_status;
    suks_pkg::t_status                 n_status;

    logic                              w_accept;
    logic                              w_hit;
    logic                              w_full;
    suks_pkg::t_cell_ctl               w_ctl;

    logic [N-1:0]                      w_lt;
    logic [N-1:0]                      w_eq;
    logic [N-1:0]                      w_valid;
    logic signed [suks_pkg::KEY_W-1:0] w_key [N];

    assign w_accept = start & ~r_pend;
    assign w_hit    = |w_eq;
    assign w_full   = (r_count == suks_pkg::CNT_W'(N));

    always_comb begin
        w_ctl.compare = w_accept;
        w_ctl.insert  = r_pend & (r_cmd == suks_pkg::CMD_INSERT) & ~w_hit & ~w_full;
        w_ctl.remove  = r_pend & (r_cmd == suks_pkg::CMD_REMOVE) & w_hit;
    end

    always_comb begin
        n_count  = r_count;
        n_status = suks_pkg::ST_NOT_FOUND;
        if (r_cmd == suks_pkg::CMD_INSERT) begin
            if (w_hit) begin
                n_status = suks_pkg::ST_DUPLICATE;
            end else if (w_full) begin
                n_status = suks_pkg::ST_FULL;
            end else begin
                n_status = suks_pkg::ST_INSERTED;
                n_count  = r_count + 1'b1;
            end
        end else if (w_hit) begin
            n_status = suks_pkg::ST_REMOVED;
            n_count  = r_count - 1'b1;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        logic                              w_prev_lt;
        logic signed [suks_pkg::KEY_W-1:0] w_prev_key;
        logic                              w_prev_valid;
        logic signed [suks_pkg::KEY_W-1:0] w_next_key;
        logic                              w_next_valid;

        if (g == 0) begin : g_head
            assign w_prev_lt    = 1'b1;
            assign w_prev_key   = '0;
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_lt    = w_lt[g-1];
            assign w_prev_key   = w_key[g-1];
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == N - 1) begin : g_tail
            assign w_next_key   = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_link
            assign w_next_key   = w_key[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        suks_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_cmp_key    (i_key),
            .i_new_key    (r_key),
            .i_prev_lt    (w_prev_lt),
            .i_prev_key   (w_prev_key),
            .i_prev_valid (w_prev_valid),
            .i_next_key   (w_next_key),
            .i_next_valid (w_next_valid),
            .o_lt         (w_lt[g]),
            .o_eq         (w_eq[g]),
            .o_key        (w_key[g]),
            .o_valid      (w_valid[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_pend <= w_accept;
            r_done <= r_pend;
            if (r_pend) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_command;
            r_key <= i_key;
        end
        if (r_pend) begin
            r_status <= n_status;
        end
    end

    assign busy           = r_pend;
    assign o_result_valid = r_done;
    assign o_status       = r_status;
    assign o_entry_count  = suks_pkg::ECNT_W'(r_count);

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result beat while a command is still resolving");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_result_valid)
        else $error("resolved command gave no result beat");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= suks_pkg::CNT_W'(N))
        else $error("entry count above capacity");

    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("slot valid bits disagree with entry count");
`endif

endmodule
`default_nettype wire

// ===== rtl/suks_cell.sv =====
// Cell: one ordered slot with its own key compare and neighbour shift.
`default_nettype none
module suks_cell (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire suks_pkg::t_cell_ctl                 i_ctl,
    input  wire logic signed [suks_pkg::KEY_W-1:0]   i_cmp_key,
    input  wire logic signed [suks_pkg::KEY_W-1:0]   i_new_key,
    input  wire logic                                i_prev_lt,
    input  wire logic signed [suks_pkg::KEY_W-1:0]   i_prev_key,
    input  wire logic                                i_prev_valid,
    input  wire logic signed [suks_pkg::KEY_W-1:0]   i_next_key,
    input  wire logic                                i_next_valid,
    output logic                                     o_lt,
    output logic                                     o_eq,
    output logic signed [suks_pkg::KEY_W-1:0]        o_key,
    output logic                                     o_valid
);

    logic signed [suks_pkg::KEY_W-1:0] r_key;
    logic signed [suks_pkg::KEY_W-1:0] n_key;
    logic                              r_valid;
    logic                              n_valid;
    logic                              r_lt;
    logic                              r_eq;

    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        if (i_ctl.insert) begin
            // slot above the insertion point takes the lower neighbour
            if (!i_prev_lt) begin
                n_key = i_prev_key;
            end else if (!r_lt) begin
                n_key = i_new_key;
            end
            n_valid = r_valid | i_prev_valid;
        end else if (i_ctl.remove) begin
            if (!r_lt) begin
                n_key   = i_next_key;
                n_valid = i_next_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (i_ctl.compare) begin
            r_lt <= r_valid & (r_key < i_cmp_key);
            r_eq <= r_valid & (r_key == i_cmp_key);
        end
    end

    assign o_lt    = r_lt;
    assign o_eq    = r_eq;
    assign o_key   = r_key;
    assign o_valid = r_valid;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the sorted unique key set: queue-fed command driver, monitor and set predictor.
`default_nettype none
module tb_top;

    localparam int N_RANDOM   = 2000;
    localparam int STALL_MAX  = 2000;
    localparam int POOL_N     = 24;

    typedef struct {
        bit                                  cmd;
        logic signed [suks_pkg::KEY_W-1:0]   key;
    } t_set_op;

    typedef struct {
        suks_pkg::t_status                   status;
        logic [suks_pkg::ECNT_W-1:0]         count;
    } t_set_reply;

    logic                                    i_clk = 1'b0;
    logic                                    i_rst_n = 1'b0;
    logic                                    start = 1'b0;
    logic                                    i_command = 1'b0;
    logic signed [suks_pkg::KEY_W-1:0]       i_key = '0;
    logic                                    busy;
    logic                                    o_result_valid;
    logic [suks_pkg::STAT_W-1:0]             o_status;
    logic [suks_pkg::ECNT_W-1:0]             o_entry_count;

    t_set_op                                 op_q[$];
    t_set_reply                              reply_q[$];
    logic signed [suks_pkg::KEY_W-1:0]       held_keys [suks_pkg::CAPACITY];
    int                                      held_n = 0;
    int                                      n_ops = 0;
    int                                      n_sent = 0;
    int                                      n_errors = 0;
    int                                      stall_cycles = 0;

    sorted_unique_key_set dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_key          (i_key),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Sorted set predictor: lower bound search, then shift up or down.
    task automatic set_apply(input bit cmd, input logic signed [suks_pkg::KEY_W-1:0] key,
                             output t_set_reply r);
        int  pos;
        int  i;
        bit  hit;
        pos = 0;
        while (pos < held_n && held_keys[pos] < key)
            pos++;
        hit = (pos < held_n) && (held_keys[pos] == key);
        if (cmd == suks_pkg::CMD_INSERT) begin
            if (hit) begin
                r.status = suks_pkg::ST_DUPLICATE;
            end else if (held_n >= suks_pkg::CAPACITY) begin
                r.status = suks_pkg::ST_FULL;
            end else begin
                for (i = held_n; i > pos; i--)
                    held_keys[i] = held_keys[i-1];
                held_keys[pos] = key;
                held_n++;
                r.status = suks_pkg::ST_INSERTED;
            end
        end else begin
            if (hit) begin
                for (i = pos; i + 1 < held_n; i++)
                    held_keys[i] = held_keys[i+1];
                held_n--;
                r.status = suks_pkg::ST_REMOVED;
            end else begin
                r.status = suks_pkg::ST_NOT_FOUND;
            end
        end
        r.count = held_n[suks_pkg::ECNT_W-1:0];
    endtask

    task automatic push_op(input bit cmd, input logic signed [suks_pkg::KEY_W-1:0] key);
        t_set_op op;
        op.cmd = cmd;
        op.key = key;
        op_q.push_back(op);
    endtask

    // Driver: sender idles 13%, then 61%, then not at all.
    always @(posedge i_clk) begin : drive
        int      idle_pct;
        t_set_op nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            case ((n_sent * 3) / (n_ops > 0 ? n_ops : 1))
                0:       idle_pct = 13;
                1:       idle_pct = 61;
                default: idle_pct = 0;
            endcase
            if (op_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt = op_q.pop_front();
                start     <= 1'b1;
                i_command <= nxt.cmd;
                i_key     <= nxt.key;
                n_sent++;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: predict on each accepted command beat, check each result beat.
    always @(posedge i_clk) begin : watch
        t_set_reply want;
        bit         moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (start && !busy) begin
                set_apply(i_command, i_key, want);
                reply_q.push_back(want);
                moved = 1'b1;
            end
            if (o_result_valid) begin
                moved = 1'b1;
                if (reply_q.size() == 0) begin
                    $display("%0t: ERROR unexpected result beat status %0d count %0d",
                             $time, o_status, o_entry_count);
                    n_errors++;
                end else begin
                    want = reply_q.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: ERROR status expected %0d actual %0d",
                                 $time, want.status, o_status);
                        n_errors++;
                    end
                    if (o_entry_count !== want.count) begin
                        $display("%0t: ERROR entry_count expected %0d actual %0d",
                                 $time, want.count, o_entry_count);
                        n_errors++;
                    end
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_MAX) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin : stim
        logic signed [suks_pkg::KEY_W-1:0] pool [POOL_N];
        int                                ins_pct;
        int                                k;
        int                                r;
        bit                                cmd;
        logic signed [suks_pkg::KEY_W-1:0] key;

        // directed: empty remove, extremes, duplicate, fill, full cases, removes
        push_op(suks_pkg::CMD_REMOVE, 32'sd3);
        push_op(suks_pkg::CMD_INSERT, 32'sh8000_0000);
        push_op(suks_pkg::CMD_INSERT, 32'sh7FFF_FFFF);
        push_op(suks_pkg::CMD_INSERT, 32'sd0);
        push_op(suks_pkg::CMD_INSERT, -32'sd1);
        push_op(suks_pkg::CMD_INSERT, 32'sd1);
        push_op(suks_pkg::CMD_INSERT, 32'sd0);
        for (k = 1; k <= 11; k++)
            push_op(suks_pkg::CMD_INSERT, 32'(10 * k));
        push_op(suks_pkg::CMD_INSERT, 32'sd5);
        push_op(suks_pkg::CMD_INSERT, 32'sd0);
        push_op(suks_pkg::CMD_REMOVE, 32'sh8000_0000);
        push_op(suks_pkg::CMD_REMOVE, 32'sh7FFF_FFFF);
        push_op(suks_pkg::CMD_REMOVE, 32'sd50);
        push_op(suks_pkg::CMD_REMOVE, 32'sd7);

        // random: segments biased to fill or drain, keys mostly from a small pool
        for (k = 0; k < N_RANDOM; k++) begin
            if (k % 128 == 0) begin
                ins_pct = ($urandom_range(1) == 1) ? 80 : 30;
                for (r = 0; r < POOL_N; r++)
                    pool[r] = $urandom;
                pool[0] = 32'sh8000_0000;
                pool[1] = 32'sh7FFF_FFFF;
                pool[2] = '0;
                pool[3] = -32'sd1;
            end
            cmd = ($urandom_range(99) < ins_pct) ? suks_pkg::CMD_INSERT
                                                 : suks_pkg::CMD_REMOVE;
            if ($urandom_range(99) < 15)
                key = $urandom;
            else
                key = pool[$urandom_range(POOL_N - 1)];
            push_op(cmd, key);
        end
        n_ops = op_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_q.size() != 0 || start)
            @(posedge i_clk);
        while (reply_q.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        if (n_errors == 0 && reply_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/suks_pkg.sv
rtl/suks_cell.sv
rtl/sorted_unique_key_set.sv
dv/tb_top.sv
